[design/rptc_pkg.sv]
// ----------------------------------------------------------------------------
// rptc_pkg: shared types and constants for the RGB tone curve core
// Pixel and result payloads, per-channel curve settings, register map and
// the fixed-point constants used by the curve lanes.
// ----------------------------------------------------------------------------
package rptc_pkg;

  // Sample and curve geometry
  localparam int SAMPLE_W   = 8;
  localparam int MAX_POINTS = 8;
  localparam int SEG_W      = $clog2(MAX_POINTS);
  localparam int POINTS_W   = MAX_POINTS * SAMPLE_W;
  localparam int COUNT_W    = 4;
  localparam int FULL_SCALE = 255;

  // x*(n-1) fits in this many bits
  localparam int PROD_W     = SAMPLE_W + SEG_W;
  // interpolation numerator, signed, holds 255*lo + (hi-lo)*frac
  localparam int NUM_W      = 2 * SAMPLE_W + 2;

  // Configuration port
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 6;
  localparam int REG_LSB    = 3;

  localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(64'hFF00);
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(2);

  // Register indexes
  typedef enum logic [ADDR_W-REG_LSB-1:0] {
    REG_RED_POINTS   = 3'd0,
    REG_GREEN_POINTS = 3'd1,
    REG_BLUE_POINTS  = 3'd2,
    REG_RED_COUNT    = 3'd3,
    REG_GREEN_COUNT  = 3'd4,
    REG_BLUE_COUNT   = 3'd5
  } reg_index_t;

  // Input pixel
  typedef struct packed {
    logic [SAMPLE_W-1:0] red_in;
    logic [SAMPLE_W-1:0] green_in;
    logic [SAMPLE_W-1:0] blue_in;
  } pixel_t;

  // Mapped pixel
  typedef struct packed {
    logic [SAMPLE_W-1:0] red_out;
    logic [SAMPLE_W-1:0] green_out;
    logic [SAMPLE_W-1:0] blue_out;
  } result_t;

  // Settings of one channel's curve
  typedef struct packed {
    logic [POINTS_W-1:0] points;
    logic [COUNT_W-1:0]  count;
  } curve_cfg_t;

endpackage

[design/rgb_piecewise_tone_curve_core.sv]
// A pixel transferred at one clock edge shows on result, with done high, once
// it has passed the lane stage 1 and 2 registers and the merge register.
// Throughput: one pixel per clock unless busy; three lanes run side by side.
// busy is high only in reset and the cycle after; the receiver cannot stall.
// Reset (rst, synchronous) clears the valid pipeline and loads identity curves.
// ----------------------------------------------------------------------------
// rgb_piecewise_tone_curve_core: per-channel piecewise-linear tone curve
// Three curve lanes fed from the register file; a merge register joins the
// lane outputs into one result transfer.
// ----------------------------------------------------------------------------
module rgb_piecewise_tone_curve_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rptc_pkg::pixel_t              pixel,
  output logic                          done,
  output rptc_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rptc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rptc_pkg::DATA_W-1:0]   pwdata,
  output logic [rptc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import rptc_pkg::*;

  curve_cfg_t          red_cfg;
  curve_cfg_t          green_cfg;
  curve_cfg_t          blue_cfg;
  logic [SAMPLE_W-1:0] red_y;
  logic [SAMPLE_W-1:0] green_y;
  logic [SAMPLE_W-1:0] blue_y;
  logic                v1;
  logic                v2;

  rptc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .red_cfg   (red_cfg),
    .green_cfg (green_cfg),
    .blue_cfg  (blue_cfg)
  );

  rptc_lane u_red   (.clk(clk), .cfg(red_cfg),   .x(pixel.red_in),   .y(red_y));
  rptc_lane u_green (.clk(clk), .cfg(green_cfg), .x(pixel.green_in), .y(green_y));
  rptc_lane u_blue  (.clk(clk), .cfg(blue_cfg),  .x(pixel.blue_in),  .y(blue_y));

  // Valid pipeline alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      v1   <= start && !busy;
      v2   <= v1;
      done <= v2;
    end
  end

  // Merge register: one transfer per pixel
  always_ff @(posedge clk) begin
    result.red_out   <= red_y;
    result.green_out <= green_y;
    result.blue_out  <= blue_y;
  end

endmodule

[design/rptc_regs.sv]
// ----------------------------------------------------------------------------
// rptc_regs: configuration register file
// APB-style slave holding the control points and point counts of the three
// channel curves. Registers sit at 8-byte strides; pready is always high.
// ----------------------------------------------------------------------------
module rptc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rptc_pkg::ADDR_W-1:0]   paddr,
  input  logic [rptc_pkg::DATA_W-1:0]   pwdata,
  output logic [rptc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output rptc_pkg::curve_cfg_t          red_cfg,
  output rptc_pkg::curve_cfg_t          green_cfg,
  output rptc_pkg::curve_cfg_t          blue_cfg
);
  import rptc_pkg::*;

  reg_index_t reg_sel;
  logic       wr_en;

  assign reg_sel = reg_index_t'(paddr[ADDR_W-1:REG_LSB]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; unmapped indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      red_cfg.points   <= POINTS_RESET;
      green_cfg.points <= POINTS_RESET;
      blue_cfg.points  <= POINTS_RESET;
      red_cfg.count    <= COUNT_RESET;
      green_cfg.count  <= COUNT_RESET;
      blue_cfg.count   <= COUNT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RED_POINTS:   red_cfg.points   <= pwdata[POINTS_W-1:0];
        REG_GREEN_POINTS: green_cfg.points <= pwdata[POINTS_W-1:0];
        REG_BLUE_POINTS:  blue_cfg.points  <= pwdata[POINTS_W-1:0];
        REG_RED_COUNT:    red_cfg.count    <= pwdata[COUNT_W-1:0];
        REG_GREEN_COUNT:  green_cfg.count  <= pwdata[COUNT_W-1:0];
        REG_BLUE_COUNT:   blue_cfg.count   <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_RED_POINTS:   prdata = DATA_W'(red_cfg.points);
      REG_GREEN_POINTS: prdata = DATA_W'(green_cfg.points);
      REG_BLUE_POINTS:  prdata = DATA_W'(blue_cfg.points);
      REG_RED_COUNT:    prdata = DATA_W'(red_cfg.count);
      REG_GREEN_COUNT:  prdata = DATA_W'(green_cfg.count);
      REG_BLUE_COUNT:   prdata = DATA_W'(blue_cfg.count);
      default:          prdata = '0;
    endcase
  end

endmodule

[design/rptc_lane.sv]
// ----------------------------------------------------------------------------
// rptc_lane: one channel of the tone curve
// Two register stages: segment/fraction lookup, then the interpolation
// product. The divide by 255 after the last register is left combinational
// and is captured by the merge register in the top level.
// ----------------------------------------------------------------------------
module rptc_lane (
  input  logic                           clk,
  input  rptc_pkg::curve_cfg_t           cfg,
  input  logic [rptc_pkg::SAMPLE_W-1:0]  x,
  output logic [rptc_pkg::SAMPLE_W-1:0]  y
);
  import rptc_pkg::*;

  logic [SEG_W-1:0]    nm1;
  logic [PROD_W-1:0]   prod;
  logic [SEG_W-1:0]    seg;
  logic [PROD_W-1:0]   frac_w;

  // stage 1 registers
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;
  logic [SAMPLE_W-1:0] frac;
  logic [SAMPLE_W-1:0] last_pt;
  logic                full;

  // stage 2 registers
  logic signed [NUM_W-1:0] num;
  logic [SAMPLE_W-1:0]     last_pt2;
  logic                    full2;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [NUM_W-1:0]    num_next;
  logic [NUM_W-1:0]           num_pos;
  logic [SAMPLE_W:0]          q0;
  logic [SAMPLE_W+1:0]        rem;
  logic [SAMPLE_W+1:0]        q;

  // Clamp point count to 2..MAX_POINTS, keep n-1
  always_comb begin
    if (cfg.count < COUNT_W'(2)) begin
      nm1 = SEG_W'(1);
    end else if (cfg.count > COUNT_W'(MAX_POINTS)) begin
      nm1 = SEG_W'(MAX_POINTS - 1);
    end else begin
      nm1 = SEG_W'(cfg.count - COUNT_W'(1));
    end
  end

  // Segment = floor(x*(n-1)/255) by parallel threshold compares
  always_comb begin
    prod = PROD_W'(x) * PROD_W'(nm1);
    seg  = '0;
    for (int k = 1; k < MAX_POINTS; k++) begin
      if (prod >= PROD_W'(k * FULL_SCALE)) seg = SEG_W'(k);
    end
    frac_w = prod - PROD_W'(seg) * PROD_W'(FULL_SCALE);
  end

  // Stage 1: fetch endpoints of the segment
  always_ff @(posedge clk) begin
    lo      <= cfg.points[{seg, 3'b000} +: SAMPLE_W];
    hi      <= cfg.points[{SEG_W'(seg + SEG_W'(1)), 3'b000} +: SAMPLE_W];
    frac    <= frac_w[SAMPLE_W-1:0];
    last_pt <= cfg.points[{nm1, 3'b000} +: SAMPLE_W];
    full    <= (x == SAMPLE_W'(FULL_SCALE));
  end

  // Interpolation numerator: 255*lo + (hi-lo)*frac
  always_comb begin
    diff     = $signed({1'b0, hi}) - $signed({1'b0, lo});
    num_next = $signed({2'b00, lo, 8'b0}) - $signed(NUM_W'(lo))
             + NUM_W'(diff * $signed({1'b0, frac}));
  end

  // Stage 2
  always_ff @(posedge clk) begin
    num      <= num_next;
    last_pt2 <= last_pt;
    full2    <= full;
  end

  // Divide by 255: q0 = num>>8 underestimates; remainder stays below 510
  always_comb begin
    num_pos = (num < 0) ? '0 : num;
    q0      = num_pos[NUM_W-2:SAMPLE_W];
    rem     = (SAMPLE_W+2)'(num_pos[SAMPLE_W-1:0]) + (SAMPLE_W+2)'(q0);
    q       = (SAMPLE_W+2)'(q0)
            + ((rem >= (SAMPLE_W+2)'(FULL_SCALE)) ? (SAMPLE_W+2)'(1) : (SAMPLE_W+2)'(0));
    if (full2) begin
      y = last_pt2;
    end else if (q > (SAMPLE_W+2)'(FULL_SCALE)) begin
      y = SAMPLE_W'(FULL_SCALE);
    end else begin
      y = q[SAMPLE_W-1:0];
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the RGB piecewise tone curve core
// Drives pixels through the command port and programs the curves through the
// APB port. Each channel is mapped by a local integer curve model, and every
// result transfer is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rptc_pkg::*;

  // Register indexes past the map; writes there must leave the curves alone
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int PIXELS_PER_PHASE = 50;

  // --------------------------------------------------------------------------
  // Curve model and in-order result checker
  // --------------------------------------------------------------------------
  class tone_scoreboard;
    logic [POINTS_W-1:0] curve_pts [3];
    logic [COUNT_W-1:0]  curve_cnt [3];
    result_t             mapped_q [$];
    int                  mismatches;

    function new();
      for (int ch = 0; ch < 3; ch++) begin
        curve_pts[ch] = POINTS_RESET;
        curve_cnt[ch] = COUNT_RESET;
      end
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_RED_POINTS:   curve_pts[0] = value[POINTS_W-1:0];
        REG_GREEN_POINTS: curve_pts[1] = value[POINTS_W-1:0];
        REG_BLUE_POINTS:  curve_pts[2] = value[POINTS_W-1:0];
        REG_RED_COUNT:    curve_cnt[0] = value[COUNT_W-1:0];
        REG_GREEN_COUNT:  curve_cnt[1] = value[COUNT_W-1:0];
        REG_BLUE_COUNT:   curve_cnt[2] = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Interpolate one sample on one channel's curve
    function logic [SAMPLE_W-1:0] tone_map(int ch, logic [SAMPLE_W-1:0] x);
      int n, xi, seg, frac, lo, hi, num, q;
      n = curve_cnt[ch];
      if (n < 2) n = 2;
      if (n > MAX_POINTS) n = MAX_POINTS;
      xi = x;
      if (xi == FULL_SCALE) return curve_pts[ch][(n-1)*SAMPLE_W +: SAMPLE_W];
      seg  = (xi * (n - 1)) / FULL_SCALE;
      frac = xi * (n - 1) - FULL_SCALE * seg;
      lo   = curve_pts[ch][seg*SAMPLE_W +: SAMPLE_W];
      hi   = curve_pts[ch][(seg+1)*SAMPLE_W +: SAMPLE_W];
      num  = lo * FULL_SCALE + (hi - lo) * frac;
      if (num < 0) num = 0;
      q = num / FULL_SCALE;
      if (q > 255) q = 255;
      return q[SAMPLE_W-1:0];
    endfunction

    function void note_pixel(pixel_t px);
      result_t r;
      r.red_out   = tone_map(0, px.red_in);
      r.green_out = tone_map(1, px.green_in);
      r.blue_out  = tone_map(2, px.blue_in);
      mapped_q.push_back(r);
    endfunction

    function int pending();
      return mapped_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (mapped_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = mapped_q.pop_front();
      if (got.red_out !== want.red_out)
        report($sformatf("red_out %h, want %h", got.red_out, want.red_out));
      if (got.green_out !== want.green_out)
        report($sformatf("green_out %h, want %h", got.green_out, want.green_out));
      if (got.blue_out !== want.blue_out)
        report($sformatf("blue_out %h, want %h", got.blue_out, want.blue_out));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  pixel_t              pixel;
  logic                done;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  tone_scoreboard curve_sb = new();

  rgb_piecewise_tone_curve_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .pixel   (pixel),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock: 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result monitor: done marks a one-cycle result transfer
  always @(posedge clk) begin
    if (!rst && done) curve_sb.check_result(result);
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Pixel transfer with a random lead-in gap; start stays high on zero gap
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int     gap;
    pixel_t px;
    gap = $urandom_range(0, 5);
    px.red_in   = r;
    px.green_in = g;
    px.blue_in  = b;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    pixel <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    curve_sb.note_pixel(px);
  endtask

  task automatic stop_pixels();
    start <= 1'b0;
  endtask

  // APB write: setup then access; psel is left high for back-to-back writes
  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << REG_LSB;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    curve_sb.write_reg(idx, value);
  endtask

  task automatic bus_idle();
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Count write with junk in the upper bits, which the register drops
  function automatic logic [DATA_W-1:0] count_word(logic [3:0] cnt);
    return {$urandom, 15'($urandom_range(0, 15'h7fff)), 13'd0, cnt};
  endfunction

  task automatic load_curves(logic [63:0] pr, logic [63:0] pg, logic [63:0] pb,
                             logic [3:0] cr, logic [3:0] cg, logic [3:0] cb);
    write_reg(REG_RED_POINTS, pr);
    write_reg(REG_GREEN_POINTS, pg);
    write_reg(REG_BLUE_POINTS, pb);
    write_reg(REG_RED_COUNT, count_word(cr));
    write_reg(REG_GREEN_COUNT, count_word(cg));
    write_reg(REG_BLUE_COUNT, count_word(cb));
    bus_idle();
  endtask

  // Let the pipeline empty before touching the registers
  task automatic wait_idle();
    while (curve_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [3:0] pick_count();
    if ($urandom_range(0, 3) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(2, 8));
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0] pr, pg, pb;
    logic [3:0]  cr, cg, cb;
    int          k;

    rst     <= 1'b1;
    start   <= 1'b0;
    pixel   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Identity curves straight out of reset
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h01, 8'h80, 8'hFE);
    send_pixel(8'h55, 8'hAA, 8'h0F);
    stop_pixels();
    wait_idle();

    // Counts below 2, above max and at 15; writes past the map are dropped
    load_curves(64'h0123456789ABCDEF, 64'hFF00FF00FF00FF00, 64'h00FFFFFFFF804020,
                4'd0, 4'd9, 4'd15);
    write_reg(REG_SPARE_A, 64'h5A5A5A5A5A5A5A5A);
    write_reg(REG_SPARE_B, 64'h0000000000000003);
    bus_idle();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd36, 8'd36, 8'd36);
    send_pixel(8'd37, 8'd37, 8'd37);
    send_pixel(8'd72, 8'd73, 8'd74);
    send_pixel(8'd127, 8'd128, 8'd127);
    send_pixel(8'd254, 8'd254, 8'd254);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd218, 8'd219, 8'd182);
    stop_pixels();
    wait_idle();

    // Falling curve, flat full-scale curve, junk bytes above the last point
    load_curves(64'h00204060809FC0FF, 64'hFFFFFFFFFFFFFFFF, 64'hDEADBEEFA5FF8000,
                4'd1, 4'd8, 4'd3);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'd127, 8'd127, 8'd127);
    send_pixel(8'd128, 8'd200, 8'd128);
    send_pixel(8'd254, 8'd1, 8'd254);
    send_pixel(8'd3, 8'd252, 8'd64);
    stop_pixels();
    wait_idle();

    // Random phases: first two at the extremes, then random curves
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        pr = '1; pg = '1; pb = '1;
        cr = 4'd8; cg = 4'd8; cb = 4'd8;
      end else if (phase == 1) begin
        pr = '0; pg = '0; pb = '0;
        cr = 4'd2; cg = 4'd2; cb = 4'd2;
      end else begin
        pr = {$urandom, $urandom};
        pg = {$urandom, $urandom};
        pb = {$urandom, $urandom};
        cr = pick_count();
        cg = pick_count();
        cb = pick_count();
      end
      load_curves(pr, pg, pb, cr, cg, cb);
      if ($urandom_range(0, 2) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  {$urandom, $urandom});
        bus_idle();
      end
      for (int i = 0; i < PIXELS_PER_PHASE; i++)
        send_pixel(pick_sample(), pick_sample(), pick_sample());
      stop_pixels();
      wait_idle();
    end

    // Final drain, bounded
    k = 0;
    while (curve_sb.pending() != 0 && k < 50) begin
      @(posedge clk);
      k++;
    end
    repeat (8) @(posedge clk);
    if (curve_sb.pending() != 0)
      curve_sb.report($sformatf("%0d results never arrived", curve_sb.pending()));

    if (curve_sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
